>>> rtl/ssdpe_pkg.sv
package ssdpe_pkg;

  localparam int SET_DEPTH   = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int IDX_W       = $clog2(SET_DEPTH);
  localparam int CNT_W       = $clog2(SET_DEPTH + 1);

  typedef enum logic [1:0] {
    REQ_RESET  = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_POP    = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SHIFT_UP,
    S_INS_WRITE,
    S_ADVANCE,
    S_SHIFT_DOWN,
    S_REM_FINISH,
    S_POP
  } state_t;

  typedef struct packed {
    logic [CNT_W-1:0] fi;
    logic [CNT_W-1:0] si;
    logic             exh;
  } adv_t;

endpackage

>>> rtl/sorted_set_diagonal_pair_enumerator.sv
// Sorted set of distinct signed values with an anti-diagonal pair walker.
// A request word (req_type, value) is taken at a rising edge with start high
// and busy low. Every request gives one result word: first_value,
// second_value and status, shown for exactly one cycle while done is high.
// The receiver cannot stall; done is simply a one-cycle pulse.
// The set lives in a single SET_DEPTH-entry RAM with registered reads;
// all searches and shifts walk it one entry per cycle.
// Steps from accept to done, with n elements and insertion point p:
//   reset pointers, failed pop: done raised straight from idle
//   pop: both pointer entries read in the same cycle, then the result
//   insert: the linear search, then a shift of the n-p entries from p upward
//   remove: the search, any pointer advances off the removed element, then
//           a shift of the n-1-p entries above p
// Insert and remove time is set by the one-entry-per-cycle search and shift through
// the RAM. busy runs from accept until done rises; a pointer reset or failed pop
// leaves busy low throughout.
// Reset (rst, synchronous) empties the set and clears both pointers and the
// exhausted flag; RAM contents are left as they are.
module sorted_set_diagonal_pair_enumerator (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [1:0]                             req_type,
  input  logic signed [ssdpe_pkg::VALUE_WIDTH-1:0] value,
  output logic                                   done,
  output logic signed [ssdpe_pkg::VALUE_WIDTH-1:0] first_value,
  output logic signed [ssdpe_pkg::VALUE_WIDTH-1:0] second_value,
  output logic [1:0]                             status
);
  import ssdpe_pkg::*;

  logic signed [VALUE_WIDTH-1:0] mem [SET_DEPTH];
  logic signed [VALUE_WIDTH-1:0] q_a, q_b;
  logic [IDX_W-1:0]              rd_addr_a, rd_addr_b, mem_waddr;
  logic signed [VALUE_WIDTH-1:0] mem_wdata;
  logic                          mem_we;

  state_t                        state, state_next;
  req_t                          req, req_next;
  logic signed [VALUE_WIDTH-1:0] val, val_next;
  logic [CNT_W-1:0]              cnt, cnt_next;
  logic [CNT_W-1:0]              fi, fi_next, si, si_next;
  logic                          exh, exh_next;
  logic [CNT_W-1:0]              scan_idx, scan_idx_next;
  logic                          pend, pend_next;
  logic [CNT_W-1:0]              pos, pos_next;
  logic                          eq, eq_next;
  logic [CNT_W-1:0]              rem, rem_next;
  logic [CNT_W-1:0]              addr, addr_next;
  logic                          wr_pend, wr_pend_next;
  logic [IDX_W-1:0]              wr_addr, wr_addr_next;
  logic                          done_next;
  logic signed [VALUE_WIDTH-1:0] first_value_next, second_value_next;
  logic [1:0]                    status_next;
  adv_t                          adv;

  // one anti-diagonal step; pointers clamp at the element count
  function automatic adv_t advance(input logic [CNT_W-1:0] f,
                                   input logic [CNT_W-1:0] s,
                                   input logic [CNT_W-1:0] n,
                                   input logic             e);
    logic [CNT_W:0] ni, nj, nn;
    adv_t           r;
    nn = {1'b0, n};
    if (s != '0) begin
      ni = {1'b0, f} + 1'b1;
      nj = {1'b0, s} - 1'b1;
    end else begin
      ni = '0;
      nj = {1'b0, f} + 1'b1;
    end
    r.exh = e || (ni >= nn) || (nj >= nn);
    r.fi  = (ni > nn) ? n : ni[CNT_W-1:0];
    r.si  = (nj > nn) ? n : nj[CNT_W-1:0];
    return r;
  endfunction

  assign busy = (state != S_IDLE);
  assign adv  = advance(fi, si, cnt, exh);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    q_a <= mem[rd_addr_a];
    q_b <= mem[rd_addr_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      cnt     <= '0;
      fi      <= '0;
      si      <= '0;
      exh     <= 1'b0;
      pend    <= 1'b0;
      wr_pend <= 1'b0;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      fi      <= fi_next;
      si      <= si_next;
      exh     <= exh_next;
      pend    <= pend_next;
      wr_pend <= wr_pend_next;
      done    <= done_next;
    end
    req          <= req_next;
    val          <= val_next;
    scan_idx     <= scan_idx_next;
    pos          <= pos_next;
    eq           <= eq_next;
    rem          <= rem_next;
    addr         <= addr_next;
    wr_addr      <= wr_addr_next;
    first_value  <= first_value_next;
    second_value <= second_value_next;
    status       <= status_next;
  end

  always_comb begin
    state_next        = state;
    req_next          = req;
    val_next          = val;
    cnt_next          = cnt;
    fi_next           = fi;
    si_next           = si;
    exh_next          = exh;
    scan_idx_next     = scan_idx;
    pend_next         = 1'b0;
    pos_next          = pos;
    eq_next           = eq;
    rem_next          = rem;
    addr_next         = addr;
    wr_pend_next      = 1'b0;
    wr_addr_next      = wr_addr;
    done_next         = 1'b0;
    first_value_next  = '0;
    second_value_next = '0;
    status_next       = ST_OK;
    rd_addr_a         = scan_idx[IDX_W-1:0];
    rd_addr_b         = si[IDX_W-1:0];
    mem_we            = 1'b0;
    mem_waddr         = wr_addr;
    mem_wdata         = q_a;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          req_next      = req_t'(req_type);
          val_next      = value;
          scan_idx_next = '0;
          unique case (req_t'(req_type))
            REQ_RESET: begin
              fi_next   = '0;
              si_next   = '0;
              exh_next  = 1'b0;
              done_next = 1'b1;
            end
            REQ_POP: begin
              if (exh || cnt == '0 || fi >= cnt || si >= cnt) begin
                status_next = ST_EXHAUSTED;
                done_next   = 1'b1;
              end else begin
                rd_addr_a  = fi[IDX_W-1:0];
                rd_addr_b  = si[IDX_W-1:0];
                state_next = S_POP;
              end
            end
            default: begin
              state_next = S_SCAN;
            end
          endcase
        end
      end

      // pipelined linear search for the first element not below val
      S_SCAN: begin
        if (pend && (q_a >= val)) begin
          pos_next   = scan_idx - 1'b1;
          eq_next    = (q_a == val);
          state_next = S_DECIDE;
        end else if (scan_idx >= cnt) begin
          pos_next   = cnt;
          eq_next    = 1'b0;
          state_next = S_DECIDE;
        end else begin
          rd_addr_a     = scan_idx[IDX_W-1:0];
          scan_idx_next = scan_idx + 1'b1;
          pend_next     = 1'b1;
        end
      end

      S_DECIDE: begin
        if (req == REQ_INSERT) begin
          if (eq) begin
            done_next  = 1'b1;
            state_next = S_IDLE;
          end else if (cnt == CNT_W'(SET_DEPTH)) begin
            status_next = ST_FULL;
            done_next   = 1'b1;
            state_next  = S_IDLE;
          end else begin
            rem_next   = cnt - pos;
            addr_next  = cnt - 1'b1;
            state_next = S_SHIFT_UP;
          end
        end else if (!eq) begin
          status_next = ST_NOT_FOUND;
          done_next   = 1'b1;
          state_next  = S_IDLE;
        end else begin
          state_next = S_ADVANCE;
        end
      end

      // read entry addr, write it one place higher next cycle
      S_SHIFT_UP: begin
        mem_we = wr_pend;
        if (rem != '0) begin
          rd_addr_a    = addr[IDX_W-1:0];
          wr_addr_next = IDX_W'(addr + 1'b1);
          addr_next    = addr - 1'b1;
          rem_next     = rem - 1'b1;
          wr_pend_next = 1'b1;
        end else begin
          state_next = S_INS_WRITE;
        end
      end

      S_INS_WRITE: begin
        mem_we     = 1'b1;
        mem_waddr  = pos[IDX_W-1:0];
        mem_wdata  = val;
        cnt_next   = cnt + 1'b1;
        fi_next    = (fi >= pos) ? fi + 1'b1 : fi;
        si_next    = (si >= pos) ? si + 1'b1 : si;
        done_next  = 1'b1;
        state_next = S_IDLE;
      end

      // step pointers off the element about to go
      S_ADVANCE: begin
        if (!exh && fi < cnt && si < cnt && (fi == pos || si == pos)) begin
          fi_next  = adv.fi;
          si_next  = adv.si;
          exh_next = adv.exh;
        end else begin
          rem_next   = cnt - 1'b1 - pos;
          addr_next  = pos + 1'b1;
          state_next = S_SHIFT_DOWN;
        end
      end

      S_SHIFT_DOWN: begin
        mem_we = wr_pend;
        if (rem != '0) begin
          rd_addr_a    = addr[IDX_W-1:0];
          wr_addr_next = IDX_W'(addr - 1'b1);
          addr_next    = addr + 1'b1;
          rem_next     = rem - 1'b1;
          wr_pend_next = 1'b1;
        end else begin
          state_next = S_REM_FINISH;
        end
      end

      S_REM_FINISH: begin
        cnt_next   = cnt - 1'b1;
        fi_next    = (fi > pos) ? fi - 1'b1 : fi;
        si_next    = (si > pos) ? si - 1'b1 : si;
        done_next  = 1'b1;
        state_next = S_IDLE;
      end

      S_POP: begin
        first_value_next  = q_a;
        second_value_next = q_b;
        fi_next           = adv.fi;
        si_next           = adv.si;
        exh_next          = adv.exh;
        done_next         = 1'b1;
        state_next        = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
